// ===== src/mcct_pkg.sv =====
// ----------------------------------------------------------------------------
// mcct_pkg
// Types, tables and command/status structs for the cell triangulator.
// ----------------------------------------------------------------------------
package mcct_pkg;

    localparam int CellW   = 10;
    localparam int ValW    = 17;
    localparam int StepW   = 32;
    localparam int PosW    = 42;
    localparam int CfgW    = 32;
    localparam int DivW    = 17;

    localparam logic [1:0] CfgIso   = 2'd0;
    localparam logic [1:0] CfgStepX = 2'd1;
    localparam logic [1:0] CfgStepY = 2'd2;
    localparam logic [1:0] CfgStepZ = 2'd3;

    typedef struct packed {
        logic [CellW-1:0] cell_i;
        logic [CellW-1:0] cell_j;
        logic [CellW-1:0] cell_k;
        logic [ValW-1:0]  corner_0;
        logic [ValW-1:0]  corner_1;
        logic [ValW-1:0]  corner_2;
        logic [ValW-1:0]  corner_3;
        logic [ValW-1:0]  corner_4;
        logic [ValW-1:0]  corner_5;
        logic [ValW-1:0]  corner_6;
        logic [ValW-1:0]  corner_7;
    } cell_in_t;

    typedef struct packed {
        logic [PosW-1:0] first_x;
        logic [PosW-1:0] first_y;
        logic [PosW-1:0] first_z;
        logic [PosW-1:0] second_x;
        logic [PosW-1:0] second_y;
        logic [PosW-1:0] second_z;
        logic [PosW-1:0] third_x;
        logic [PosW-1:0] third_y;
        logic [PosW-1:0] third_z;
        logic            last_triangle;
    } tri_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EDGE,
        ST_DIV,
        ST_MULX,
        ST_MULY,
        ST_MULZ,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture cell, compute cube index
        logic       edge_setup;// set up edge of current vertex
        logic       div_step;  // one divider iteration
        logic       mul_x;
        logic       mul_y;
        logic       mul_z;
        logic       store_vtx; // write vertex into slot
        logic [1:0] slot;      // 0 first, 1 second, 2 third
        logic [3:0] edge_sel;
        logic       last;
        logic       emit;      // load output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       in_range;
        logic [7:0] cube;
        logic       div_done;
    } dp_stat_t;

    function automatic logic [2:0] edge_a(input logic [3:0] e);
        logic [2:0] r;
        begin
            unique case (e)
                4'd0: r = 3'd0;  4'd1: r = 3'd1;  4'd2: r = 3'd2;  4'd3: r = 3'd3;
                4'd4: r = 3'd4;  4'd5: r = 3'd5;  4'd6: r = 3'd6;  4'd7: r = 3'd7;
                4'd8: r = 3'd0;  4'd9: r = 3'd1;  4'd10: r = 3'd2; 4'd11: r = 3'd3;
                default: r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [2:0] edge_b(input logic [3:0] e);
        logic [2:0] r;
        begin
            unique case (e)
                4'd0: r = 3'd1;  4'd1: r = 3'd2;  4'd2: r = 3'd3;  4'd3: r = 3'd0;
                4'd4: r = 3'd5;  4'd5: r = 3'd6;  4'd6: r = 3'd7;  4'd7: r = 3'd4;
                4'd8: r = 3'd4;  4'd9: r = 3'd5;  4'd10: r = 3'd6; 4'd11: r = 3'd7;
                default: r = 3'd1;
            endcase
            return r;
        end
    endfunction

    // corner offset bits {z,y,x}
    function automatic logic [2:0] corner_off(input logic [2:0] c);
        logic [2:0] r;
        begin
            unique case (c)
                3'd0: r = 3'b000; 3'd1: r = 3'b001; 3'd2: r = 3'b011; 3'd3: r = 3'b010;
                3'd4: r = 3'b100; 3'd5: r = 3'b101; 3'd6: r = 3'b111; 3'd7: r = 3'b110;
                default: r = 3'b000;
            endcase
            return r;
        end
    endfunction

    // Triangle table row: edge nibbles in a 60-bit field, entry 0 in bits [3:0]; count of triangles.
    typedef struct packed {
        logic [2:0]  ntri;
        logic [59:0] edges;
    } tri_row_t;

    function automatic tri_row_t row_pack(input string s);
        tri_row_t r;
        int n;
        logic [3:0] e;
        begin
            r = '0;
            n = s.len();
            for (int i = 0; i < 15; i++) begin
                if (i < n) begin
                    if (s[i] >= "0" && s[i] <= "9") e = 4'(s[i] - "0");
                    else e = 4'(s[i] - "a" + 10);
                    r.edges[i*4 +: 4] = e;
                end
            end
            r.ntri = 3'(n / 3);
            return r;
        end
    endfunction

    function automatic tri_row_t tri_row(input logic [7:0] c);
        string s;
        begin
            unique case (c)
            8'd0: s=""; 8'd1: s="083"; 8'd2: s="019"; 8'd3: s="183981";
            8'd4: s="12a"; 8'd5: s="08312a"; 8'd6: s="92a029"; 8'd7: s="2832a8a98";
            8'd8: s="3b2"; 8'd9: s="0b28b0"; 8'd10: s="19023b"; 8'd11: s="1b219b98b";
            8'd12: s="3a1ba3"; 8'd13: s="0a108a8ba"; 8'd14: s="3903b9ba9"; 8'd15: s="98aa8b";
            8'd16: s="478"; 8'd17: s="430734"; 8'd18: s="019847"; 8'd19: s="419471731";
            8'd20: s="12a847"; 8'd21: s="34730412a"; 8'd22: s="92a902847";
            8'd23: s="2a9297273794";
            8'd24: s="8473b2"; 8'd25: s="b47b24204"; 8'd26: s="90184723b";
            8'd27: s="47b94b9b2921";
            8'd28: s="3a13ba784"; 8'd29: s="1ba14b1047b4"; 8'd30: s="47890b9bab03";
            8'd31: s="47b4b99ba";
            8'd32: s="954"; 8'd33: s="954083"; 8'd34: s="054150"; 8'd35: s="854835315";
            8'd36: s="12a954"; 8'd37: s="30812a495"; 8'd38: s="52a542402";
            8'd39: s="2a5325354348";
            8'd40: s="9543b2"; 8'd41: s="0b208b495"; 8'd42: s="05401523b";
            8'd43: s="21525828b485";
            8'd44: s="a3ba13954"; 8'd45: s="4950818a18ba"; 8'd46: s="54050b5bab03";
            8'd47: s="54858aa8b";
            8'd48: s="978579"; 8'd49: s="930953573"; 8'd50: s="078017157"; 8'd51: s="153357";
            8'd52: s="978957a12"; 8'd53: s="a12950530573"; 8'd54: s="802825857a52";
            8'd55: s="2a5253357";
            8'd56: s="7957893b2"; 8'd57: s="95797292027b"; 8'd58: s="23b018178157";
            8'd59: s="b21b17715";
            8'd60: s="958857a13a3b"; 8'd61: s="5705097b010aba0"; 8'd62: s="ba0b03a50807570";
            8'd63: s="ba57b5";
            8'd64: s="a65"; 8'd65: s="0835a6"; 8'd66: s="9015a6"; 8'd67: s="1831985a6";
            8'd68: s="165261"; 8'd69: s="165126308"; 8'd70: s="965906026";
            8'd71: s="598582526328";
            8'd72: s="23ba65"; 8'd73: s="b08b20a65"; 8'd74: s="01923b5a6";
            8'd75: s="5a61929b298b";
            8'd76: s="63b653513"; 8'd77: s="08b0b50515b6"; 8'd78: s="3b6036065059";
            8'd79: s="65969bb98";
            8'd80: s="5a6478"; 8'd81: s="43047365a"; 8'd82: s="1905a6847";
            8'd83: s="a65197173794";
            8'd84: s="612651478"; 8'd85: s="125526304347"; 8'd86: s="847905065026";
            8'd87: s="739794329596269";
            8'd88: s="3b2784a65"; 8'd89: s="5a647242027b"; 8'd90: s="01947823b5a6";
            8'd91: s="9219b294b7b45a6";
            8'd92: s="8473b53515b6"; 8'd93: s="51b5b610b7b404b"; 8'd94: s="059065036b63847";
            8'd95: s="65969b4797b9";
            8'd96: s="a4964a"; 8'd97: s="4a649a083"; 8'd98: s="a01a60640";
            8'd99: s="83181686461a";
            8'd100: s="149124264"; 8'd101: s="308129249264"; 8'd102: s="024426";
            8'd103: s="832824426";
            8'd104: s="a49a64b23"; 8'd105: s="08228b49a4a6"; 8'd106: s="3b201606461a";
            8'd107: s="64161a48121b8b1";
            8'd108: s="964936913b63"; 8'd109: s="8b1810b61914641"; 8'd110: s="3b6360064";
            8'd111: s="648b68";
            8'd112: s="7a678a89a"; 8'd113: s="0730a709a67a"; 8'd114: s="a671a7178180";
            8'd115: s="a67a71173";
            8'd116: s="126168189867"; 8'd117: s="269291679093739"; 8'd118: s="780706602";
            8'd119: s="732672";
            8'd120: s="23ba68a89867"; 8'd121: s="20727b09767a9a7"; 8'd122: s="1801781a767a23b";
            8'd123: s="b21b17a61671";
            8'd124: s="896867916b63136"; 8'd125: s="091b67"; 8'd126: s="7807063b0b60";
            8'd127: s="7b6";
            8'd128: s="76b"; 8'd129: s="308b76"; 8'd130: s="019b76"; 8'd131: s="819831b76";
            8'd132: s="a126b7"; 8'd133: s="12a3086b7"; 8'd134: s="2902a96b7";
            8'd135: s="6b72a3a83a98";
            8'd136: s="723627"; 8'd137: s="708760620"; 8'd138: s="276237019";
            8'd139: s="162186198876";
            8'd140: s="a76a17137"; 8'd141: s="a7617a187108"; 8'd142: s="03707a0a96a7";
            8'd143: s="76a7a88a9";
            8'd144: s="684b86"; 8'd145: s="36b306046"; 8'd146: s="86b846901";
            8'd147: s="946963931b36";
            8'd148: s="6846b82a1"; 8'd149: s="12a30b06b046"; 8'd150: s="4b846b0292a9";
            8'd151: s="a93a32943b36463";
            8'd152: s="823842462"; 8'd153: s="042462"; 8'd154: s="190234246438";
            8'd155: s="194142246";
            8'd156: s="8138618466a1"; 8'd157: s="a10a06604"; 8'd158: s="4634386a3039a93";
            8'd159: s="a946a4";
            8'd160: s="49576b"; 8'd161: s="083495b76"; 8'd162: s="50154076b";
            8'd163: s="b76834354315";
            8'd164: s="954a1276b"; 8'd165: s="6b712a083495"; 8'd166: s="76b54a42a402";
            8'd167: s="348354325a52b76";
            8'd168: s="723762549"; 8'd169: s="954086062687"; 8'd170: s="362376150540";
            8'd171: s="628687218485158";
            8'd172: s="954a16176137"; 8'd173: s="16a176107870954"; 8'd174: s="40a4a503a6a737a";
            8'd175: s="76a7a854a48a";
            8'd176: s="6956b9b89"; 8'd177: s="36b063056095"; 8'd178: s="0b805b01556b";
            8'd179: s="6b3635531";
            8'd180: s="12a95b9b8b56"; 8'd181: s="0b306b09656912a"; 8'd182: s="b85b56805a52025";
            8'd183: s="6b36352a3a53";
            8'd184: s="589528562382"; 8'd185: s="956960062"; 8'd186: s="158180568382628";
            8'd187: s="156216";
            8'd188: s="13616a386569896"; 8'd189: s="a10a06950560"; 8'd190: s="03856a";
            8'd191: s="a56";
            8'd192: s="b5a75b"; 8'd193: s="b5ab75830"; 8'd194: s="5b75ab190";
            8'd195: s="a75ab7981831";
            8'd196: s="b12b71751"; 8'd197: s="08312717572b"; 8'd198: s="9759279022b7";
            8'd199: s="75272b592328982";
            8'd200: s="25a235375"; 8'd201: s="820852875a25"; 8'd202: s="9015a35373a2";
            8'd203: s="982921872a25752";
            8'd204: s="135375"; 8'd205: s="087071175"; 8'd206: s="903935537";
            8'd207: s="987597";
            8'd208: s="5845a8ab8"; 8'd209: s="5045b05abb30"; 8'd210: s="01984a8aba45";
            8'd211: s="ab4a45b34941314";
            8'd212: s="2512852b8458"; 8'd213: s="04b0b345b2b151b"; 8'd214: s="0250592b5458b85";
            8'd215: s="9452b3";
            8'd216: s="25a352345384"; 8'd217: s="5a2524420"; 8'd218: s="3a235a385458019";
            8'd219: s="5a2524192942";
            8'd220: s="845853351"; 8'd221: s="045105"; 8'd222: s="845853905035";
            8'd223: s="945";
            8'd224: s="4b749b9ab"; 8'd225: s="0834979b79ab"; 8'd226: s="1ab1b414074b";
            8'd227: s="3143481a474bab4";
            8'd228: s="4b79b492b912"; 8'd229: s="9749b791b2b1083"; 8'd230: s="b74b42240";
            8'd231: s="b74b42834324";
            8'd232: s="29a279237749"; 8'd233: s="9a7974a27870207"; 8'd234: s="37a3a274a1a040a";
            8'd235: s="1a2874";
            8'd236: s="491417713"; 8'd237: s="491417081871"; 8'd238: s="403743";
            8'd239: s="487";
            8'd240: s="9a8ab8"; 8'd241: s="30939bb9a"; 8'd242: s="01a0a88ab";
            8'd243: s="31ab3a";
            8'd244: s="12b1b99b8"; 8'd245: s="30939b1292b9"; 8'd246: s="02b80b";
            8'd247: s="32b";
            8'd248: s="23828aa89"; 8'd249: s="9a2092"; 8'd250: s="23828a0181a8";
            8'd251: s="1a2";
            8'd252: s="138918"; 8'd253: s="091"; 8'd254: s="038"; 8'd255: s="";
            default: s="";
            endcase
            return row_pack(s);
        end
    endfunction

endpackage

// ===== src/marching_cubes_cell_triangulator_top.sv =====
// ----------------------------------------------------------------------------
// marching_cubes_cell_triangulator_top
// Marching cubes triangulator for one grid cell per beat.
// ----------------------------------------------------------------------------
// One cell is taken at a time. Each vertex goes through edge setup, a
// bit-serial 49-bit divider that rounds t*step, the three axis multiplies
// and a store. A triangle is three vertices plus the load of the output
// register. A cell yields up to five triangles, and the next cell is taken
// once its last triangle is loaded, which waits while a result beat is
// still unclaimed. Empty, full or out-of-grid cells go from the load state
// straight back to idle. One result beat is held in an output register;
// the next triangle waits only if it is still unclaimed.
module marching_cubes_cell_triangulator_top #(
    parameter int GRID_SIZE = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcct_pkg::cell_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mcct_pkg::tri_out_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [16:0] iso_reg;
    logic [31:0] sx_reg, sy_reg, sz_reg;
    mcct_pkg::dp_cmd_t  cmd;
    mcct_pkg::dp_stat_t stat;
    logic idle, in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_reg <= 17'd32768;
            sx_reg  <= 32'd65536;
            sy_reg  <= 32'd65536;
            sz_reg  <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcct_pkg::CfgIso:   iso_reg <= cfg_data[16:0];
                mcct_pkg::CfgStepX: sx_reg  <= cfg_data;
                mcct_pkg::CfgStepY: sy_reg  <= cfg_data;
                mcct_pkg::CfgStepZ: sz_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = idle;
    assign in_fire  = in_valid && idle;

    mcct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid && !out_ready),
        .stat     (stat),
        .idle     (idle),
        .cmd      (cmd)
    );

    mcct_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (in_data),
        .iso       (iso_reg),
        .step_x    (sx_reg),
        .step_y    (sy_reg),
        .step_z    (sz_reg),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== src/mcct_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcct_ctrl
// Sequencer: walks triangles and vertices of a cell, drives the datapath.
// ----------------------------------------------------------------------------
module mcct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                out_busy,
    input  mcct_pkg::dp_stat_t  stat,
    output logic                idle,
    output mcct_pkg::dp_cmd_t   cmd
);

    mcct_pkg::state_t  state_reg, state_next;
    logic [2:0]        tri_reg, tri_next;
    logic [1:0]        vtx_reg, vtx_next;
    mcct_pkg::tri_row_t row;
    logic [3:0]        ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcct_pkg::ST_IDLE;
            tri_reg   <= '0;
            vtx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tri_reg   <= tri_next;
            vtx_reg   <= vtx_next;
        end
    end

    assign row = mcct_pkg::tri_row(stat.cube);

    // vertex slot order: first=t, second=t+2, third=t+1
    always_comb
    begin
        unique case (vtx_reg)
            2'd0:    ent = 4'(tri_reg * 3);
            2'd1:    ent = 4'(tri_reg * 3 + 2);
            default: ent = 4'(tri_reg * 3 + 1);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        tri_next   = tri_reg;
        vtx_next   = vtx_reg;
        cmd        = '0;
        cmd.slot   = vtx_reg;
        cmd.edge_sel = row.edges[ent*4 +: 4];
        cmd.last   = (3'(tri_reg + 3'd1) == row.ntri);
        idle       = 1'b0;
        unique case (state_reg)
            mcct_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                    state_next = mcct_pkg::ST_LOAD;
            end
            mcct_pkg::ST_LOAD:
            begin
                tri_next = '0;
                vtx_next = '0;
                if (!stat.in_range || row.ntri == 3'd0)
                    state_next = mcct_pkg::ST_IDLE;
                else
                    state_next = mcct_pkg::ST_EDGE;
            end
            mcct_pkg::ST_EDGE:
            begin
                cmd.edge_setup = 1'b1;
                state_next = mcct_pkg::ST_DIV;
            end
            mcct_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = mcct_pkg::ST_MULX;
            end
            mcct_pkg::ST_MULX:
            begin
                cmd.mul_x = 1'b1;
                state_next = mcct_pkg::ST_MULY;
            end
            mcct_pkg::ST_MULY:
            begin
                cmd.mul_y = 1'b1;
                state_next = mcct_pkg::ST_MULZ;
            end
            mcct_pkg::ST_MULZ:
            begin
                cmd.mul_z = 1'b1;
                state_next = mcct_pkg::ST_NEXT;
            end
            mcct_pkg::ST_NEXT:
            begin
                cmd.store_vtx = 1'b1;
                if (vtx_reg == 2'd2)
                begin
                    vtx_next = '0;
                    state_next = mcct_pkg::ST_EMIT;
                end
                else
                begin
                    vtx_next = vtx_reg + 2'd1;
                    state_next = mcct_pkg::ST_EDGE;
                end
            end
            mcct_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.emit = 1'b1;
                    if (cmd.last)
                        state_next = mcct_pkg::ST_IDLE;
                    else
                    begin
                        tri_next = tri_reg + 3'd1;
                        state_next = mcct_pkg::ST_EDGE;
                    end
                end
            end
            default: state_next = mcct_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_tri_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tri_reg <= 3'd4)
        else $error("triangle count overrun");
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_busy)
        else $error("emit into full output");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == mcct_pkg::ST_LOAD)
        else $error("load lost");
`endif

endmodule

// ===== src/mcct_dp.sv =====
// ----------------------------------------------------------------------------
// mcct_dp
// Datapath: cell capture, edge interpolation divider, position multipliers.
// ----------------------------------------------------------------------------
module mcct_dp #(
    parameter int GRID_SIZE = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcct_pkg::cell_in_t   cell_in,
    input  logic [16:0]          iso,
    input  logic [31:0]          step_x,
    input  logic [31:0]          step_y,
    input  logic [31:0]          step_z,
    input  mcct_pkg::dp_cmd_t    cmd,
    output mcct_pkg::dp_stat_t   stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mcct_pkg::tri_out_t   out_data
);

    logic [9:0]  ci_reg, cj_reg, ck_reg;
    logic [16:0] val_reg [8];
    logic [7:0]  cube_reg;
    logic        in_range_reg;

    logic [16:0] num_reg;     // numerator of t = num/den
    logic [16:0] den_reg;
    logic [2:0]  oa_reg, ob_reg;
    logic [47:0] off_reg;     // round(t*step)
    logic [41:0] px_reg, py_reg, pz_reg;
    logic [41:0] vtx_reg [3][3];
    mcct_pkg::tri_out_t out_reg;
    logic        out_valid_reg;

    // exact rounding: off = floor((step*num + den/2)/den); computed as
    // remainder-based long division of step*num + den/2 by den over 32+17 bits
    logic [48:0] prod_reg;
    logic [47:0] dq_reg;
    logic [16:0] drem_reg;
    logic [5:0]  dcnt_reg;
    logic [1:0]  dphase_reg;

    logic [16:0] va, vb;
    logic signed [18:0] na, dn;
    logic [18:0] na_abs, dn_abs;
    logic [2:0]  ea, eb;
    logic [2:0]  axis;        // axis along the edge
    logic [31:0] stp;
    logic [17:0] trial;

    function automatic logic [41:0] pos(input logic [9:0] c, input logic [31:0] s,
                                        input int d);
        logic [2:0]  a3, b3;
        logic [63:0] base;
        logic [63:0] r;
        begin
            a3 = mcct_pkg::corner_off(oa_reg);
            b3 = mcct_pkg::corner_off(ob_reg);
            if (a3[d] == b3[d])
                base = 64'(c + 11'(a3[d])) * 64'(s);
            else if (b3[d])
                base = 64'(c) * 64'(s);
            else
                base = 64'(11'(c) + 11'd1) * 64'(s);
            if (a3[d] == b3[d])
                r = base;
            else if (b3[d])
                r = base + 64'(off_reg);
            else
                r = base - 64'(off_reg);
            return r[41:0];
        end
    endfunction

    assign ea = mcct_pkg::edge_a(cmd.edge_sel);
    assign eb = mcct_pkg::edge_b(cmd.edge_sel);
    assign va = val_reg[ea];
    assign vb = val_reg[eb];
    assign na = $signed({2'b00, iso}) - $signed({2'b00, va});
    assign dn = $signed({2'b00, vb}) - $signed({2'b00, va});
    assign na_abs = na[18] ? 19'(-na) : 19'(na);
    assign dn_abs = dn[18] ? 19'(-dn) : 19'(dn);

    always_comb
    begin
        axis = mcct_pkg::corner_off(oa_reg) ^ mcct_pkg::corner_off(ob_reg);
        unique case (1'b1)
            axis[0]: stp = step_x;
            axis[1]: stp = step_y;
            default: stp = step_z;
        endcase
    end

    assign trial = {drem_reg, prod_reg[48]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ci_reg <= cell_in.cell_i;
            cj_reg <= cell_in.cell_j;
            ck_reg <= cell_in.cell_k;
            val_reg[0] <= cell_in.corner_0; val_reg[1] <= cell_in.corner_1;
            val_reg[2] <= cell_in.corner_2; val_reg[3] <= cell_in.corner_3;
            val_reg[4] <= cell_in.corner_4; val_reg[5] <= cell_in.corner_5;
            val_reg[6] <= cell_in.corner_6; val_reg[7] <= cell_in.corner_7;
            cube_reg <= {cell_in.corner_7 >= iso, cell_in.corner_6 >= iso,
                         cell_in.corner_5 >= iso, cell_in.corner_4 >= iso,
                         cell_in.corner_3 >= iso, cell_in.corner_2 >= iso,
                         cell_in.corner_1 >= iso, cell_in.corner_0 >= iso};
            in_range_reg <= (32'(cell_in.cell_i) + 32'd2 <= 32'(GRID_SIZE)) &&
                            (32'(cell_in.cell_j) + 32'd2 <= 32'(GRID_SIZE)) &&
                            (32'(cell_in.cell_k) + 32'd2 <= 32'(GRID_SIZE));
        end
        if (cmd.edge_setup)
        begin
            oa_reg <= ea;
            ob_reg <= eb;
            dphase_reg <= 2'd0;
            if (dn == 19'sd0)
            begin
                num_reg <= 17'd1; den_reg <= 17'd2;
            end
            else if (na == 19'sd0 || ((na < 0) != (dn < 0)))
            begin
                num_reg <= 17'd0; den_reg <= 17'd1;
            end
            else if (na_abs >= dn_abs)
            begin
                num_reg <= 17'd1; den_reg <= 17'd1;
            end
            else
            begin
                num_reg <= na_abs[16:0];
                den_reg <= dn_abs[16:0];
            end
        end
        if (cmd.div_step)
        begin
            unique case (dphase_reg)
                2'd0:
                begin
                    prod_reg   <= 49'(stp) * 49'(num_reg) + 49'(den_reg >> 1);
                    drem_reg   <= '0;
                    dq_reg     <= '0;
                    dcnt_reg   <= '0;
                    dphase_reg <= 2'd1;
                end
                2'd1:
                begin
                    prod_reg <= {prod_reg[47:0], 1'b0};
                    if (trial >= {1'b0, den_reg})
                    begin
                        drem_reg <= 17'(trial - {1'b0, den_reg});
                        dq_reg   <= {dq_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= trial[16:0];
                        dq_reg   <= {dq_reg[46:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd48)
                        dphase_reg <= 2'd2;
                end
                default:
                begin
                    off_reg <= dq_reg;
                end
            endcase
        end
        if (cmd.mul_x)
            px_reg <= pos(ci_reg, step_x, 0);
        if (cmd.mul_y)
            py_reg <= pos(cj_reg, step_y, 1);
        if (cmd.mul_z)
            pz_reg <= pos(ck_reg, step_z, 2);
        if (cmd.store_vtx)
        begin
            vtx_reg[cmd.slot][0] <= px_reg;
            vtx_reg[cmd.slot][1] <= py_reg;
            vtx_reg[cmd.slot][2] <= pz_reg;
        end
        if (cmd.emit)
        begin
            out_reg.first_x  <= vtx_reg[0][0];
            out_reg.first_y  <= vtx_reg[0][1];
            out_reg.first_z  <= vtx_reg[0][2];
            out_reg.second_x <= vtx_reg[1][0];
            out_reg.second_y <= vtx_reg[1][1];
            out_reg.second_z <= vtx_reg[1][2];
            out_reg.third_x  <= vtx_reg[2][0];
            out_reg.third_y  <= vtx_reg[2][1];
            out_reg.third_z  <= vtx_reg[2][2];
            out_reg.last_triangle <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign stat.in_range = in_range_reg;
    assign stat.cube     = cube_reg;
    assign stat.div_done = (dphase_reg == 2'd2);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !cmd.emit |=> $stable(out_data))
        else $error("result changed while held");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid || out_ready)
        else $error("result overwritten");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dphase_reg == 2'd1) |-> (dcnt_reg <= 6'd48))
        else $error("divider overrun");
`endif

endmodule

// ===== sim/tb_marching_cubes_cell_triangulator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_marching_cubes_cell_triangulator_top
// Self-checking bench for the marching cubes cell triangulator.
// Cells are driven on a valid/ready channel and every triangle beat is checked
// against a local predictor: cube index, triangle table, edge interpolation
// with rounding and clamping, and reversed winding. Runs through several
// threshold and spacing settings under varied idling on both channels.
// ----------------------------------------------------------------------------
module tb_marching_cubes_cell_triangulator_top;

    localparam int GridSize  = 1024;
    localparam int StallLim  = 20000;
    localparam int RandCells = 75;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    mcct_pkg::cell_in_t in_data;
    logic        out_valid;
    logic        out_ready;
    mcct_pkg::tri_out_t out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int errors;
    int idle_cycles;
    int cells_in;
    int tris_out;
    int send_idle_pct;
    int recv_stall_pct;

    marching_cubes_cell_triangulator_top #(.GRID_SIZE(GridSize)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    class tri_scoreboard;
        logic [16:0] iso;
        logic [31:0] step [3];
        mcct_pkg::tri_out_t tri_q [$];
        string       rows [256];
        int          ends_a [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
        int          ends_b [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};
        int          offs [8][3] = '{'{0, 0, 0}, '{1, 0, 0}, '{1, 1, 0}, '{0, 1, 0},
                                     '{0, 0, 1}, '{1, 0, 1}, '{1, 1, 1}, '{0, 1, 1}};

        function new();
            rows = '{
                "", "083", "019", "183981", "12a", "08312a", "92a029", "2832a8a98",
                "3b2", "0b28b0", "19023b", "1b219b98b", "3a1ba3", "0a108a8ba",
                "3903b9ba9", "98aa8b",
                "478", "430734", "019847", "419471731", "12a847", "34730412a",
                "92a902847", "2a9297273794",
                "8473b2", "b47b24204", "90184723b", "47b94b9b2921", "3a13ba784",
                "1ba14b1047b4", "47890b9bab03", "47b4b99ba",
                "954", "954083", "054150", "854835315", "12a954", "30812a495",
                "52a542402", "2a5325354348",
                "9543b2", "0b208b495", "05401523b", "21525828b485", "a3ba13954",
                "4950818a18ba", "54050b5bab03", "54858aa8b",
                "978579", "930953573", "078017157", "153357", "978957a12",
                "a12950530573", "802825857a52", "2a5253357",
                "7957893b2", "95797292027b", "23b018178157", "b21b17715",
                "958857a13a3b", "5705097b010aba0", "ba0b03a50807570", "ba57b5",
                "a65", "0835a6", "9015a6", "1831985a6", "165261", "165126308",
                "965906026", "598582526328",
                "23ba65", "b08b20a65", "01923b5a6", "5a61929b298b", "63b653513",
                "08b0b50515b6", "3b6036065059", "65969bb98",
                "5a6478", "43047365a", "1905a6847", "a65197173794", "612651478",
                "125526304347", "847905065026", "739794329596269",
                "3b2784a65", "5a647242027b", "01947823b5a6", "9219b294b7b45a6",
                "8473b53515b6", "51b5b610b7b404b", "059065036b63847", "65969b4797b9",
                "a4964a", "4a649a083", "a01a60640", "83181686461a", "149124264",
                "308129249264", "024426", "832824426",
                "a49a64b23", "08228b49a4a6", "3b201606461a", "64161a48121b8b1",
                "964936913b63", "8b1810b61914641", "3b6360064", "648b68",
                "7a678a89a", "0730a709a67a", "a671a7178180", "a67a71173",
                "126168189867", "269291679093739", "780706602", "732672",
                "23ba68a89867", "20727b09767a9a7", "1801781a767a23b", "b21b17a61671",
                "896867916b63136", "091b67", "7807063b0b60", "7b6",
                "76b", "308b76", "019b76", "819831b76", "a126b7", "12a3086b7",
                "2902a96b7", "6b72a3a83a98",
                "723627", "708760620", "276237019", "162186198876", "a76a17137",
                "a7617a187108", "03707a0a96a7", "76a7a88a9",
                "684b86", "36b306046", "86b846901", "946963931b36", "6846b82a1",
                "12a30b06b046", "4b846b0292a9", "a93a32943b36463",
                "823842462", "042462", "190234246438", "194142246", "8138618466a1",
                "a10a06604", "4634386a3039a93", "a946a4",
                "49576b", "083495b76", "50154076b", "b76834354315", "954a1276b",
                "6b712a083495", "76b54a42a402", "348354325a52b76",
                "723762549", "954086062687", "362376150540", "628687218485158",
                "954a16176137", "16a176107870954", "40a4a503a6a737a", "76a7a854a48a",
                "6956b9b89", "36b063056095", "0b805b01556b", "6b3635531",
                "12a95b9b8b56", "0b306b09656912a", "b85b56805a52025", "6b36352a3a53",
                "589528562382", "956960062", "158180568382628", "156216",
                "13616a386569896", "a10a06950560", "03856a", "a56",
                "b5a75b", "b5ab75830", "5b75ab190", "a75ab7981831", "b12b71751",
                "08312717572b", "9759279022b7", "75272b592328982",
                "25a235375", "820852875a25", "9015a35373a2", "982921872a25752",
                "135375", "087071175", "903935537", "987597",
                "5845a8ab8", "5045b05abb30", "01984a8aba45", "ab4a45b34941314",
                "2512852b8458", "04b0b345b2b151b", "0250592b5458b85", "9452b3",
                "25a352345384", "5a2524420", "3a235a385458019", "5a2524192942",
                "845853351", "045105", "845853905035", "945",
                "4b749b9ab", "0834979b79ab", "1ab1b414074b", "3143481a474bab4",
                "4b79b492b912", "9749b791b2b1083", "b74b42240", "b74b42834324",
                "29a279237749", "9a7974a27870207", "37a3a274a1a040a", "1a2874",
                "491417713", "491417081871", "403743", "487",
                "9a8ab8", "30939bb9a", "01a0a88ab", "31ab3a", "12b1b99b8",
                "30939b1292b9", "02b80b", "32b",
                "23828aa89", "9a2092", "23828a0181a8", "1a2", "138918", "091",
                "038", ""};
            iso = 17'd32768;
            foreach (step[d]) step[d] = 32'd65536;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                mcct_pkg::CfgIso:   iso = val[16:0];
                mcct_pkg::CfgStepX: step[0] = val;
                mcct_pkg::CfgStepY: step[1] = val;
                mcct_pkg::CfgStepZ: step[2] = val;
                default: ;
            endcase
        endfunction

        function int edge_num(byte ch);
            if (ch >= "a") return ch - "a" + 10;
            return ch - "0";
        endfunction

        function void vertex(int e, longint unsigned cidx [3], longint unsigned val [8],
                             output logic [41:0] pos [3]);
            int ca, cb;
            longint na, dn;
            longint unsigned num, den, p, off;
            ca = ends_a[e];
            cb = ends_b[e];
            na = longint'(iso) - longint'(val[ca]);
            dn = longint'(val[cb]) - longint'(val[ca]);
            if (dn == 0) begin
                num = 1;
                den = 2;
            end else if (na == 0 || ((na < 0) != (dn < 0))) begin
                num = 0;
                den = 1;
            end else begin
                num = (na < 0) ? -na : na;
                den = (dn < 0) ? -dn : dn;
                if (num >= den) begin
                    num = 1;
                    den = 1;
                end
            end
            for (int d = 0; d < 3; d++) begin
                if (offs[ca][d] == offs[cb][d]) begin
                    p = (cidx[d] + offs[ca][d]) * step[d];
                end else begin
                    off = (longint'(step[d]) * num + den / 2) / den;
                    if (offs[cb][d] > offs[ca][d]) p = cidx[d] * step[d] + off;
                    else p = (cidx[d] + 1) * step[d] - off;
                end
                pos[d] = p[41:0];
            end
        endfunction

        function void note_cell(mcct_pkg::cell_in_t c);
            longint unsigned cidx [3];
            longint unsigned val [8];
            logic [7:0] cube;
            string row;
            int ntri;
            logic [41:0] p0 [3], p1 [3], p2 [3];
            mcct_pkg::tri_out_t t;
            cidx = '{c.cell_i, c.cell_j, c.cell_k};
            val = '{c.corner_0, c.corner_1, c.corner_2, c.corner_3,
                    c.corner_4, c.corner_5, c.corner_6, c.corner_7};
            foreach (cidx[d]) if (cidx[d] > GridSize - 2) return;
            foreach (val[n]) cube[n] = (val[n] >= iso);
            row = rows[cube];
            ntri = row.len() / 3;
            if (ntri > 5) ntri = 5;
            for (int k = 0; k < ntri; k++) begin
                vertex(edge_num(row[3*k]), cidx, val, p0);
                vertex(edge_num(row[3*k+2]), cidx, val, p1);
                vertex(edge_num(row[3*k+1]), cidx, val, p2);
                t.first_x = p0[0];  t.first_y = p0[1];  t.first_z = p0[2];
                t.second_x = p1[0]; t.second_y = p1[1]; t.second_z = p1[2];
                t.third_x = p2[0];  t.third_y = p2[1];  t.third_z = p2[2];
                t.last_triangle = (k + 1 == ntri);
                tri_q = {tri_q, t};
            end
        endfunction

        function string check(mcct_pkg::tri_out_t got);
            mcct_pkg::tri_out_t e;
            string s;
            if (tri_q.size() == 0) return "triangle beat with none expected";
            e = tri_q.pop_front();
            s = "";
            if (got.first_x !== e.first_x) s = {s, " first_x"};
            if (got.first_y !== e.first_y) s = {s, " first_y"};
            if (got.first_z !== e.first_z) s = {s, " first_z"};
            if (got.second_x !== e.second_x) s = {s, " second_x"};
            if (got.second_y !== e.second_y) s = {s, " second_y"};
            if (got.second_z !== e.second_z) s = {s, " second_z"};
            if (got.third_x !== e.third_x) s = {s, " third_x"};
            if (got.third_y !== e.third_y) s = {s, " third_y"};
            if (got.third_z !== e.third_z) s = {s, " third_z"};
            if (got.last_triangle !== e.last_triangle) s = {s, " last_triangle"};
            if (s != "") s = {"mismatch in", s};
            return s;
        endfunction
    endclass

    tri_scoreboard sb;

    task automatic report(string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk) begin
        string msg;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_cell(in_data);
                cells_in++;
            end
            if (out_valid && out_ready) begin
                msg = sb.check(out_data);
                tris_out++;
                if (msg != "") report(msg);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= StallLim) begin
                $display("watchdog: no beat for %0d cycles", StallLim);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_cell(mcct_pkg::cell_in_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.tri_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic mcct_pkg::cell_in_t make_cell(logic [9:0] ci, logic [9:0] cj,
                                                     logic [9:0] ck, logic [16:0] v [8]);
        mcct_pkg::cell_in_t c;
        c.cell_i = ci; c.cell_j = cj; c.cell_k = ck;
        c.corner_0 = v[0]; c.corner_1 = v[1]; c.corner_2 = v[2]; c.corner_3 = v[3];
        c.corner_4 = v[4]; c.corner_5 = v[5]; c.corner_6 = v[6]; c.corner_7 = v[7];
        return c;
    endfunction

    function automatic mcct_pkg::cell_in_t rand_cell();
        logic [16:0] v [8];
        logic [7:0] cube;
        logic [9:0] idx [3];
        int mode;
        mode = $urandom_range(99);
        cube = 8'($urandom_range(255));
        foreach (idx[d]) idx[d] = 10'($urandom_range(GridSize - 2));
        if (mode < 4) idx[$urandom_range(2)] = 10'($urandom_range(1023, GridSize - 1));
        foreach (v[n]) begin
            if (mode < 80) begin
                if (cube[n]) v[n] = 17'($urandom_range(65536, sb.iso));
                else v[n] = (sb.iso == 0) ? 17'd0 : 17'($urandom_range(sb.iso - 1));
            end else if (mode < 90) begin
                v[n] = 17'($urandom_range(17'h1ffff));
            end else begin
                v[n] = cube[n] ? sb.iso : 17'(sb.iso - 1);
            end
        end
        if (mode >= 85 && mode < 90) v[1] = v[0];
        return make_cell(idx[0], idx[1], idx[2], v);
    endfunction

    task automatic run_random(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RandCells) send_cell(rand_cell());
        drain();
    endtask

    initial begin
        logic [16:0] v [8];
        sb = new();
        errors = 0;
        idle_cycles = 0;
        cells_in = 0;
        tris_out = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = mcct_pkg::CfgIso;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed cells at reset settings
        v = '{default: 17'd0};
        send_cell(make_cell(10'd0, 10'd0, 10'd0, v));
        v = '{default: 17'd65536};
        send_cell(make_cell(10'd5, 10'd6, 10'd7, v));
        v = '{default: 17'd0};
        v[0] = 17'd32768;
        send_cell(make_cell(10'd1, 10'd2, 10'd3, v));
        v = '{default: 17'd32768};
        v[6] = 17'd0;
        send_cell(make_cell(10'd1022, 10'd1022, 10'd1022, v));
        v = '{17'd65536, 17'd0, 17'd65536, 17'd0, 17'd0, 17'd65536, 17'd0, 17'd65536};
        send_cell(make_cell(10'd3, 10'd4, 10'd5, v));
        v = '{17'h1ffff, 17'd0, 17'h1ffff, 17'd0, 17'd0, 17'h1ffff, 17'd0, 17'h1ffff};
        send_cell(make_cell(10'd1022, 10'd0, 10'd511, v));
        v = '{17'd40000, 17'd40000, 17'd0, 17'd0, 17'd40000, 17'd0, 17'd0, 17'd0};
        send_cell(make_cell(10'd9, 10'd9, 10'd9, v));
        v = '{17'd32767, 17'd32769, 17'd100, 17'd65535, 17'd1, 17'd32768, 17'd2, 17'd0};
        send_cell(make_cell(10'd512, 10'd256, 10'd128, v));
        // corner values that give a cube row with five triangles
        v = '{17'd60000, 17'd0, 17'd60000, 17'd60000, 17'd60000, 17'd60000,
              17'd0, 17'd0};
        send_cell(make_cell(10'd100, 10'd200, 10'd300, v));
        v = '{default: 17'd40000};
        v[2] = 17'd0;
        send_cell(make_cell(10'd1023, 10'd0, 10'd0, v));
        send_cell(make_cell(10'd0, 10'd1023, 10'd0, v));
        send_cell(make_cell(10'd0, 10'd0, 10'd1023, v));
        drain();

        cfg_write(mcct_pkg::CfgIso, 32'd1);
        cfg_write(mcct_pkg::CfgStepX, 32'd0);
        cfg_write(mcct_pkg::CfgStepY, 32'hffffffff);
        cfg_write(mcct_pkg::CfgStepZ, 32'd3);
        v = '{17'd0, 17'd1, 17'd0, 17'd1, 17'd1, 17'd0, 17'd1, 17'd0};
        send_cell(make_cell(10'd1022, 10'd1022, 10'd1022, v));
        v = '{17'd0, 17'd0, 17'd2, 17'd0, 17'd0, 17'd1, 17'd0, 17'd0};
        send_cell(make_cell(10'd7, 10'd1, 10'd2, v));
        run_random(0, 0);

        cfg_write(mcct_pkg::CfgIso, 32'd65536);
        cfg_write(mcct_pkg::CfgStepX, $urandom());
        cfg_write(mcct_pkg::CfgStepY, 32'd0);
        cfg_write(mcct_pkg::CfgStepZ, 32'hffffffff);
        run_random(82, 0);

        cfg_write(mcct_pkg::CfgIso, $urandom_range(65536, 1));
        cfg_write(mcct_pkg::CfgStepX, 32'hffffffff);
        cfg_write(mcct_pkg::CfgStepY, $urandom());
        cfg_write(mcct_pkg::CfgStepZ, $urandom_range(1 << 20));
        run_random(0, 82);

        cfg_write(mcct_pkg::CfgIso, $urandom_range(65536, 1));
        cfg_write(mcct_pkg::CfgStepX, $urandom());
        cfg_write(mcct_pkg::CfgStepY, $urandom());
        cfg_write(mcct_pkg::CfgStepZ, $urandom());
        run_random(33, 33);

        repeat (200) @(posedge clk);
        if (sb.tri_q.size() != 0) report($sformatf("%0d triangles never arrived",
                                                    sb.tri_q.size()));
        $display("covered %0d cells and %0d triangle beats over 5 register settings",
                 cells_in, tris_out);
        $display("idling: none, sender 82%%, receiver 82%%, both 33%%");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mcct_pkg.sv
src/mcct_ctrl.sv
src/mcct_dp.sv
src/marching_cubes_cell_triangulator_top.sv
sim/tb_marching_cubes_cell_triangulator_top.sv
